@@ hw/rtl/swarq_pkg.sv @@
// Package for the stop-and-wait ARQ endpoint.
// Holds sizes, request/result codes, register indexes and the result record.
// No dependencies.
package swarq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W      = QCNT_W + 1;

  localparam int OQ_DEPTH    = 4;
  localparam int OQ_IDX_W    = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  RETRIES_RESET = 8'd5;

  localparam logic CFG_TIMEOUT     = 1'b0;
  localparam logic CFG_MAX_RETRIES = 1'b1;

  typedef enum logic [1:0] {
    REQ_SEND = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_DATA = 2'd2,
    REQ_TICK = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    K_DATA    = 3'd0,
    K_ACK     = 3'd1,
    K_DELIVER = 3'd2,
    K_DIED    = 3'd3,
    K_REJECT  = 3'd4,
    K_DROP    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] tag;
    logic        last;
  } res_t;

endpackage

@@ hw/rtl/stop_and_wait_arq_endpoint.sv @@
// Stop-and-wait ARQ endpoint top level.
// Uses swarq_pkg and swarq_ram (send queue storage).
//
// Usage:
//   Input channel (in_valid/in_stall) carries events: send request, ack
//   received, data received, tick. A transfer happens when in_valid is high
//   and in_stall is low. Each event yields zero, one or two results on the
//   output channel (out_valid/out_stall); out_last marks the final one.
//   An accepted event is registered and executed once the result queue has
//   room (the send queue RAM read issued at acceptance has returned by then);
//   its results are presented from the cycle after execution.
//   Throughput: one event per cycle while results drain; the output port
//   moves one result per cycle while out_stall is low.
//   Execution needs two free slots in the four-entry result queue.
//   When the receiver stalls, the result queue fills, execution holds and
//   in_stall rises; nothing is lost. Reset (rst_n low, synchronous):
//   timeout 1000 ticks, 5 retries, link active, nothing in flight, queue
//   empty. No clearing pass is needed. The user writes configuration
//   (cfg_we/cfg_index/cfg_data) only while idle; the block does not check.
module stop_and_wait_arq_endpoint
  import swarq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_seq_num,
  input  logic [31:0] in_ack_num,
  input  logic [15:0] in_payload_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [15:0] out_tag,
  output logic        out_last
);

  logic [15:0]         timeout_r;
  logic [7:0]          max_retries_r;
  logic [31:0]         nss_r, nss_nxt;
  logic [31:0]         ers_r, ers_nxt;
  logic                awaiting_r, awaiting_nxt;
  logic                link_r, link_nxt;
  logic [7:0]          retry_r, retry_nxt;
  logic [15:0]         timer_r, timer_nxt;
  logic [TAG_BITS-1:0] ift_r, ift_nxt;
  logic [QIDX_W-1:0]   head_r, head_nxt;
  logic [QCNT_W-1:0]   qcnt_r, qcnt_nxt;

  logic                ex_valid_r;
  req_t                ex_req_r;
  logic [31:0]         ex_seq_r;
  logic [31:0]         ex_ack_r;
  logic [TAG_BITS-1:0] ex_tag_r;
  logic                fwd_valid_r;
  logic [TAG_BITS-1:0] fwd_data_r;

  res_t                oq_r [OQ_DEPTH];
  logic [OQ_IDX_W-1:0] orp_r, owp_r;
  logic [OQ_CNT_W-1:0] ocnt_r;

  logic                in_accept, out_pop, room, ex_go;
  logic                q_we;
  logic [QIDX_W-1:0]   q_waddr;
  logic [TAG_BITS-1:0] q_rdata, q_data;
  logic [QSUM_W-1:0]   slot_sum;
  logic [1:0]          nres;
  res_t                res0, res1;

  // send queue storage
  swarq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (ex_tag_r),
    .re    (in_accept),
    .raddr (head_nxt),
    .rdata (q_rdata)
  );

  assign out_pop   = (ocnt_r != '0) && !out_stall;
  assign room      = (ocnt_r <= OQ_CNT_W'(OQ_DEPTH - 2)) ||
                     ((ocnt_r == OQ_CNT_W'(OQ_DEPTH - 1)) && out_pop);
  assign ex_go     = ex_valid_r && room;
  assign in_stall  = ex_valid_r && !room;
  assign in_accept = in_valid && !in_stall;
  assign q_data    = fwd_valid_r ? fwd_data_r : q_rdata;

  always_comb begin
    slot_sum = QSUM_W'(head_r) + QSUM_W'(qcnt_r);
    if (slot_sum >= QSUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - QSUM_W'(QUEUE_DEPTH);
    end
  end
  assign q_waddr = slot_sum[QIDX_W-1:0];

  // event execution
  always_comb begin
    nss_nxt      = nss_r;
    ers_nxt      = ers_r;
    awaiting_nxt = awaiting_r;
    link_nxt     = link_r;
    retry_nxt    = retry_r;
    timer_nxt    = timer_r;
    ift_nxt      = ift_r;
    head_nxt     = head_r;
    qcnt_nxt     = qcnt_r;
    q_we         = 1'b0;
    nres         = 2'd0;
    res0         = '{kind: K_DATA, seq: '0, ack: '0, tag: '0, last: 1'b1};
    res1         = '{kind: K_ACK, seq: '0, ack: '0, tag: '0, last: 1'b1};
    if (ex_go) begin
      case (ex_req_r)
        REQ_SEND: begin
          if (!link_r) begin
            nres      = 2'd1;
            res0.kind = K_REJECT;
            res0.tag  = 16'(ex_tag_r);
          end else if (!awaiting_r) begin
            nss_nxt      = nss_r + 32'd1;
            awaiting_nxt = 1'b1;
            ift_nxt      = ex_tag_r;
            retry_nxt    = '0;
            timer_nxt    = timeout_r;
            nres         = 2'd1;
            res0.kind    = K_DATA;
            res0.seq     = nss_r + 32'd1;
            res0.tag     = 16'(ex_tag_r);
          end else if (qcnt_r == QCNT_W'(QUEUE_DEPTH)) begin
            nres      = 2'd1;
            res0.kind = K_DROP;
            res0.tag  = 16'(ex_tag_r);
          end else begin
            q_we     = 1'b1;
            qcnt_nxt = qcnt_r + QCNT_W'(1);
          end
        end
        REQ_ACK: begin
          if (ex_ack_r == nss_r + 32'd1) begin
            awaiting_nxt = 1'b0;
            timer_nxt    = '0;
            ift_nxt      = '0;
            if (qcnt_r != '0) begin
              head_nxt     = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 :
                             head_r + QIDX_W'(1);
              qcnt_nxt     = qcnt_r - QCNT_W'(1);
              nss_nxt      = nss_r + 32'd1;
              awaiting_nxt = 1'b1;
              ift_nxt      = q_data;
              retry_nxt    = '0;
              timer_nxt    = timeout_r;
              nres         = 2'd1;
              res0.kind    = K_DATA;
              res0.seq     = nss_r + 32'd1;
              res0.tag     = 16'(q_data);
            end
          end
        end
        REQ_DATA: begin
          if (ex_seq_r == ers_r) begin
            ers_nxt   = ers_r + 32'd1;
            nres      = 2'd2;
            res0.kind = K_DELIVER;
            res0.tag  = 16'(ex_tag_r);
            res0.last = 1'b0;
            res1.ack  = ers_r + 32'd1;
          end else begin
            nres      = 2'd1;
            res0.kind = K_ACK;
            res0.ack  = ers_r;
          end
        end
        default: begin
          if (awaiting_r) begin
            if (timer_r > 16'd1) begin
              timer_nxt = timer_r - 16'd1;
            end else if (retry_r >= max_retries_r) begin
              awaiting_nxt = 1'b0;
              link_nxt     = 1'b0;
              timer_nxt    = '0;
              head_nxt     = '0;
              qcnt_nxt     = '0;
              nres         = 2'd1;
              res0.kind    = K_DIED;
              res0.tag     = 16'(ift_r);
            end else begin
              retry_nxt = retry_r + 8'd1;
              timer_nxt = timeout_r;
              nres      = 2'd1;
              res0.kind = K_DATA;
              res0.seq  = nss_r;
              res0.tag  = 16'(ift_r);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RESET;
      max_retries_r <= RETRIES_RESET;
      nss_r         <= '0;
      ers_r         <= 32'd1;
      awaiting_r    <= 1'b0;
      link_r        <= 1'b1;
      retry_r       <= '0;
      timer_r       <= '0;
      ift_r         <= '0;
      head_r        <= '0;
      qcnt_r        <= '0;
      ex_valid_r    <= 1'b0;
      fwd_valid_r   <= 1'b0;
      orp_r         <= '0;
      owp_r         <= '0;
      ocnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:     timeout_r     <= cfg_data;
          CFG_MAX_RETRIES: max_retries_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      nss_r      <= nss_nxt;
      ers_r      <= ers_nxt;
      awaiting_r <= awaiting_nxt;
      link_r     <= link_nxt;
      retry_r    <= retry_nxt;
      timer_r    <= timer_nxt;
      ift_r      <= ift_nxt;
      head_r     <= head_nxt;
      qcnt_r     <= qcnt_nxt;
      if (in_accept) begin
        ex_valid_r  <= 1'b1;
        // write to the entry being read this cycle: forward it
        fwd_valid_r <= q_we && (q_waddr == head_nxt);
      end else if (ex_go) begin
        ex_valid_r  <= 1'b0;
      end
      if (ex_go && (nres != 2'd0)) begin
        owp_r <= owp_r + OQ_IDX_W'(nres);
      end
      if (out_pop) begin
        orp_r <= orp_r + OQ_IDX_W'(1);
      end
      ocnt_r <= ocnt_r - OQ_CNT_W'(out_pop) + OQ_CNT_W'(nres);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_req_r   <= req_t'(in_req_type);
      ex_seq_r   <= in_seq_num;
      ex_ack_r   <= in_ack_num;
      ex_tag_r   <= TAG_BITS'(in_payload_tag);
      fwd_data_r <= ex_tag_r;
    end
    if (nres != 2'd0) begin
      oq_r[owp_r] <= res0;
    end
    if (nres == 2'd2) begin
      oq_r[owp_r + OQ_IDX_W'(1)] <= res1;
    end
  end

  assign out_valid = (ocnt_r != '0);
  assign out_kind  = oq_r[orp_r].kind;
  assign out_seq   = oq_r[orp_r].seq;
  assign out_ack   = oq_r[orp_r].ack;
  assign out_tag   = oq_r[orp_r].tag;
  assign out_last  = oq_r[orp_r].last;

  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("send queue overflow");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_r |-> (qcnt_r == '0))
    else $error("send queue holds tags while nothing is in flight");

  a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !link_r |-> (!awaiting_r && (qcnt_r == '0)))
    else $error("dead link still has traffic pending");

  a_ex_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid_r && !room) |=> (ex_valid_r && $stable(ex_req_r) && $stable(ex_tag_r)))
    else $error("held event changed while waiting for result space");

endmodule

@@ hw/rtl/swarq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds until the next read enable. No dependencies.
module swarq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/sv/swarq_monitor.sv @@
// Result checker for the stop-and-wait ARQ endpoint.
// Follows every transfer and register write, predicts the results and compares them.
// Depends on swarq_pkg.
module swarq_monitor
  import swarq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_seq_num,
  input  logic [31:0] in_ack_num,
  input  logic [15:0] in_payload_tag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [31:0] out_seq,
  input  logic [31:0] out_ack,
  input  logic [15:0] out_tag,
  input  logic        out_last,
  output int          fail_count,
  output int          results_due,
  output logic [31:0] tx_seq,
  output logic [31:0] rx_seq
);

  logic [15:0] timeout_ticks = TIMEOUT_RESET;
  logic [7:0]  retry_limit = RETRIES_RESET;
  logic [31:0] sent_seq = '0;
  logic [31:0] recv_seq = 32'd1;
  logic        busy = 1'b0;
  logic        alive = 1'b1;
  logic [7:0]  retries = '0;
  logic [15:0] timer = '0;
  logic [15:0] flight_tag = '0;
  logic [15:0] backlog [QUEUE_DEPTH];
  int          head = 0;
  int          count = 0;
  int          fails = 0;
  res_t        step_res [2];
  int          step_n;
  res_t        endpoint_results [$];

  task automatic emit(input kind_t k, input logic [31:0] s, input logic [31:0] a,
                      input logic [15:0] t);
    step_res[step_n].kind = k;
    step_res[step_n].seq  = s;
    step_res[step_n].ack  = a;
    step_res[step_n].tag  = t;
    step_res[step_n].last = 1'b0;
    step_n++;
  endtask

  task automatic start_segment(input logic [15:0] t);
    sent_seq   = sent_seq + 32'd1;
    busy       = 1'b1;
    flight_tag = t;
    retries    = '0;
    timer      = timeout_ticks;
    emit(K_DATA, sent_seq, '0, t);
  endtask

  task automatic advance_endpoint(input logic [1:0] req, input logic [31:0] seq,
                                  input logic [31:0] ack, input logic [15:0] tag);
    logic [15:0] t;
    step_n = 0;
    case (req_t'(req))
      REQ_SEND: begin
        if (!alive) emit(K_REJECT, '0, '0, tag);
        else if (!busy) start_segment(tag);
        else if (count >= QUEUE_DEPTH) emit(K_DROP, '0, '0, tag);
        else begin
          backlog[(head + count) % QUEUE_DEPTH] = tag;
          count++;
        end
      end
      REQ_ACK: begin
        if (ack == sent_seq + 32'd1) begin
          busy       = 1'b0;
          timer      = '0;
          flight_tag = '0;
          if (count > 0) begin
            t    = backlog[head];
            head = (head + 1) % QUEUE_DEPTH;
            count--;
            start_segment(t);
          end
        end
      end
      REQ_DATA: begin
        if (seq == recv_seq) begin
          emit(K_DELIVER, '0, '0, tag);
          recv_seq = recv_seq + 32'd1;
        end
        emit(K_ACK, '0, recv_seq, '0);
      end
      default: begin
        if (busy) begin
          if (timer > 16'd1) timer = timer - 16'd1;
          else if (retries >= retry_limit) begin
            busy  = 1'b0;
            alive = 1'b0;
            timer = '0;
            head  = 0;
            count = 0;
            emit(K_DIED, '0, '0, flight_tag);
          end else begin
            retries = retries + 8'd1;
            timer   = timeout_ticks;
            emit(K_DATA, sent_seq, '0, flight_tag);
          end
        end
      end
    endcase
    if (step_n > 0) begin
      step_res[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) endpoint_results.push_back(step_res[i]);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      timeout_ticks = TIMEOUT_RESET;
      retry_limit   = RETRIES_RESET;
      sent_seq      = '0;
      recv_seq      = 32'd1;
      busy          = 1'b0;
      alive         = 1'b1;
      retries       = '0;
      timer         = '0;
      flight_tag    = '0;
      head          = 0;
      count         = 0;
      endpoint_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (endpoint_results.size() == 0) begin
          $error("unexpected result: kind %0d tag %0h", out_kind, out_tag);
          fails++;
        end else begin
          want = endpoint_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            fails++;
          end
          if (out_seq !== want.seq) begin
            $error("out_seq: expected %0h, got %0h", want.seq, out_seq);
            fails++;
          end
          if (out_ack !== want.ack) begin
            $error("out_ack: expected %0h, got %0h", want.ack, out_ack);
            fails++;
          end
          if (out_tag !== want.tag) begin
            $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_ticks = cfg_data;
        else retry_limit = cfg_data[7:0];
      end
      if (in_valid && !in_stall)
        advance_endpoint(in_req_type, in_seq_num, in_ack_num, in_payload_tag);
    end
    fail_count  <= fails;
    results_due <= endpoint_results.size();
    tx_seq      <= sent_seq;
    rx_seq      <= recv_seq;
  end

endmodule

@@ tb/sv/tb_stop_and_wait_arq_endpoint.sv @@
// Top of the stop-and-wait ARQ endpoint testbench: clock, reset, stimulus and verdict.
// Instantiates stop_and_wait_arq_endpoint and swarq_monitor; uses swarq_pkg.
module tb_stop_and_wait_arq_endpoint;
  import swarq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 760;
  localparam int SETTLE_CYCLES  = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_TIMEOUT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_TICK;
  logic [31:0] in_seq_num = '0;
  logic [31:0] in_ack_num = '0;
  logic [15:0] in_payload_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [15:0] out_tag;
  logic        out_last;

  int          fail_count;
  int          results_due;
  logic [31:0] tx_seq;
  logic [31:0] rx_seq;
  int          in_xfers = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          held_off = 1'b0;

  stop_and_wait_arq_endpoint dut (.*);

  swarq_monitor monitor (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) in_xfers <= in_xfers + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic drive(input req_t req, input logic [31:0] seq, input logic [31:0] ack,
                       input logic [15:0] tag);
    int gap;
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_seq_num     <= seq;
    in_ack_num     <= ack;
    in_payload_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_regs(input logic [15:0] ticks, input logic [7:0] limit);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_index <= CFG_MAX_RETRIES;
    cfg_data  <= {8'($urandom), limit};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_run(input int n);
    int   mode;
    int   r;
    req_t req;
    logic [31:0] seq;
    logic [31:0] ack;
    mode = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        mode  = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 5) == 0);
      end
      r = $urandom_range(0, 99);
      case (mode)
        0:       req = (r < 30) ? REQ_SEND : (r < 55) ? REQ_ACK : (r < 75) ? REQ_DATA : REQ_TICK;
        1:       req = (r < 70) ? REQ_SEND : (r < 75) ? REQ_ACK : (r < 90) ? REQ_DATA : REQ_TICK;
        default: req = (r < 10) ? REQ_SEND : (r < 45) ? REQ_ACK : (r < 60) ? REQ_DATA : REQ_TICK;
      endcase
      seq = $urandom();
      ack = $urandom();
      r = $urandom_range(0, 99);
      if (req == REQ_ACK) begin
        if (r < 70) ack = tx_seq + 32'd1;
        else if (r < 80) ack = tx_seq;
      end else if (req == REQ_DATA) begin
        if (r < 65) seq = rx_seq;
        else if (r < 80) seq = rx_seq - 32'd1;
      end
      drive(req, seq, ack, 16'($urandom_range(0, 65535)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    int run;
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && in_xfers >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      stall = $urandom_range(0, 99);
      run = (stall < 70) ? $urandom_range(1, 4) :
            (stall < 90) ? $urandom_range(5, 20) : $urandom_range(40, 100);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      stall = $urandom_range(0, 99);
      stall = (stall < 40) ? 0 : (stall < 85) ? $urandom_range(1, 3) :
              (stall < 96) ? $urandom_range(4, 15) : $urandom_range(20, 60);
      if (stall > 0) begin
        out_stall <= 1'b1;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values; in-order, duplicate and far-off data, stray acks and ticks
    drive(REQ_DATA, 32'd1, 32'hFFFF_FFFF, 16'hFFFF);
    drive(REQ_DATA, 32'd0, 32'd0, 16'h1234);
    drive(REQ_DATA, 32'hFFFF_FFFF, 32'h0, 16'h0000);
    drive(REQ_ACK, 32'hFFFF_FFFF, 32'd1, 16'h0000);
    drive(REQ_ACK, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
    drive(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    drive(REQ_SEND, 32'd0, 32'd0, 16'hFFFF);
    // overfill the send queue by one
    for (int i = 0; i <= QUEUE_DEPTH; i++) drive(REQ_SEND, 32'd0, 32'd0, 16'(i));
    drive(REQ_ACK, 32'd0, 32'd1, 16'h0000);
    drive(REQ_ACK, 32'd0, 32'd2, 16'h0000);
    drive(REQ_TICK, 32'd0, 32'd0, 16'h0000);

    set_regs(16'd1, 8'd200);
    random_run(230);
    set_regs(16'd3, 8'd255);
    random_run(230);
    set_regs(16'd0, 8'd128);
    random_run(200);
    set_regs(16'd7, 8'd64);
    random_run(250);
    set_regs(16'hFFFF, 8'd255);
    random_run(150);
    set_regs(16'd2, 8'd100);
    random_run(230);
    set_regs(16'd16, 8'd50);
    random_run(230);

    // no retries left: the link dies at the first timeout, later sends are rejected
    set_regs(16'd5, 8'd0);
    drive(REQ_SEND, 32'd0, 32'd0, 16'hA5A5);
    repeat (20) drive(REQ_TICK, 32'd0, 32'd0, 16'h0000);
    drive(REQ_SEND, 32'd0, 32'd0, 16'h5A5A);
    random_run(300);

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
